// ===== sv/fbpa_pkg.sv =====
// Package for the fixed block pool allocator: field widths, codes and FSM type.
// No dependencies; imported by the interfaces and by the top level.
package fbpa_pkg;

   localparam int ADDR_W    = 48;
   localparam int SIZE_W    = 25;
   localparam int COUNT_W   = 11;
   localparam int CSR_IDX_W = 2;

   // request operation codes
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // register indexes on the csr channel
   localparam logic [CSR_IDX_W-1:0] CSR_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 2'd2;

   localparam logic [ADDR_W-1:0]  BASE_RST  = '0;
   localparam logic [SIZE_W-1:0]  SIZE_RST  = 25'd256;
   localparam logic [COUNT_W-1:0] COUNT_RST = 11'd1024;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_BAD_ADDR = 2'd2,
      STAT_FULL     = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_MUL,
      S_ADDB,
      S_SUB,
      S_OVF,
      S_DIV,
      S_CHECK,
      S_DONE
   } state_type;

endpackage

// ===== sv/fbpa_if.sv =====
// Handshake channels of the allocator: request, response and csr write.
// Depends on fbpa_pkg for field widths.
interface fbpa_req_if import fbpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] addr;

   modport source (output valid, func, addr, input ready);
   modport sink   (input valid, func, addr, output ready);
endinterface

interface fbpa_rsp_if import fbpa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] block_address;
   logic [1:0]        status;

   modport source (output valid, block_address, status, input ready);
   modport sink   (input valid, block_address, status, output ready);
endinterface

interface fbpa_csr_if import fbpa_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: fresh blocks in address order, then a FIFO of returns.
// Alloc: base + index*size; free: subtract base, bound check, divide, check.
// One word at a time; a new request is taken once the previous result is in rsp regs.
// Cost is set by the single 48-bit adder: shift-add multiply and restoring divide.
// Reset (sync, active high): csrs to defaults, counters and pointers cleared;
// the return queue RAM is not cleared and is only read where already written.
module fixed_block_pool_allocator import fbpa_pkg::*; #(
   parameter int MAX_BLOCKS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   fbpa_req_if.sink    req_bus,
   fbpa_rsp_if.source  rsp_bus,
   fbpa_csr_if.sink    csr_bus
);

   localparam int IDX_W  = $clog2(MAX_BLOCKS);       // queue index / pointer width
   localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);   // counts up to MAX_BLOCKS
   localparam int STEP_W = $clog2(CNT_W);            // serial step counter

   // ---------------------------------------------------------------- registers
   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  base_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [COUNT_W-1:0] count_ff;

   logic [CNT_W-1:0]   fresh_ff, fresh_in;
   logic [IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;

   logic               func_ff, func_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [ADDR_W-1:0]  acc_ff, acc_in;     // product / offset / remainder
   logic [CNT_W-1:0]   q_ff, q_in;         // multiplier bits / quotient
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   status_type         status_ff, status_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_addr_ff, rsp_addr_in;
   status_type         rsp_status_ff, rsp_status_in;

   // return queue RAM, registered read
   logic [IDX_W-1:0]   queue_mem [MAX_BLOCKS];
   logic [IDX_W-1:0]   rd_q_ff;
   logic               mem_we;

   // ---------------------------------------------------------- shared adder
   logic [ADDR_W-1:0]  add_a, add_b, add_b_eff;
   logic               add_sub;
   logic [ADDR_W:0]    add_sum;     // top bit: carry, i.e. a >= b on subtract

   assign add_b_eff = add_sub ? ~add_b : add_b;
   assign add_sum   = {1'b0, add_a} + {1'b0, add_b_eff} + (ADDR_W+1)'(add_sub);

   // blocks in use: block_count clipped to the queue depth
   logic [CNT_W-1:0]   count_eff;
   always_comb begin
      if (32'(count_ff) > 32'(MAX_BLOCKS)) begin
         count_eff = CNT_W'(MAX_BLOCKS);
      end else begin
         count_eff = CNT_W'(count_ff);
      end
   end

   function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] r;
      if (p == IDX_W'(MAX_BLOCKS - 1)) begin
         r = '0;
      end else begin
         r = p + IDX_W'(1);
      end
      return r;
   endfunction

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.block_address = rsp_addr_ff;
   assign rsp_bus.status        = rsp_status_ff;

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in      = state_ff;
      fresh_in      = fresh_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      fill_in       = fill_ff;
      func_in       = func_ff;
      addr_in       = addr_ff;
      acc_in        = acc_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      mem_we        = 1'b0;
      add_a         = acc_ff;
      add_b         = '0;
      add_sub       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               func_in   = req_bus.func;
               addr_in   = req_bus.addr;
               acc_in    = '0;
               status_in = STAT_OK;
               cnt_in    = STEP_W'(CNT_W - 1);
               if (req_bus.func == FUNC_FREE) begin
                  state_in = S_SUB;
               end else if (fresh_ff < count_eff) begin
                  q_in     = fresh_ff;
                  fresh_in = fresh_ff + CNT_W'(1);
                  state_in = S_MUL;
               end else if (fill_ff != '0) begin
                  // rd_q_ff picks up the head entry at this edge
                  rd_ptr_in = ptr_next(rd_ptr_ff);
                  fill_in   = fill_ff - CNT_W'(1);
                  state_in  = S_LOAD;
               end else begin
                  status_in = STAT_EMPTY;
                  state_in  = S_DONE;
               end
            end
         end
         S_LOAD: begin
            q_in     = CNT_W'(rd_q_ff);
            state_in = S_MUL;
         end
         S_MUL: begin
            // MSB-first shift-add: acc = 2*acc + bit*size
            add_a  = acc_ff << 1;
            add_b  = q_ff[CNT_W-1] ? ADDR_W'(size_ff) : '0;
            acc_in = add_sum[ADDR_W-1:0];
            q_in   = q_ff << 1;
            if (cnt_ff == '0) begin
               state_in = S_ADDB;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         S_ADDB: begin
            add_a    = acc_ff;
            add_b    = base_ff;
            acc_in   = add_sum[ADDR_W-1:0];
            state_in = S_DONE;
         end
         S_SUB: begin
            // offset = addr - base; below base or zero size is invalid
            add_a   = addr_ff;
            add_b   = base_ff;
            add_sub = 1'b1;
            if (!add_sum[ADDR_W] || size_ff == '0) begin
               status_in = STAT_BAD_ADDR;
               state_in  = S_DONE;
            end else begin
               acc_in   = add_sum[ADDR_W-1:0];
               state_in = S_OVF;
            end
         end
         S_OVF: begin
            // quotient must fit CNT_W bits: (offset >> CNT_W) < size
            add_a   = acc_ff >> CNT_W;
            add_b   = ADDR_W'(size_ff);
            add_sub = 1'b1;
            if (add_sum[ADDR_W]) begin
               status_in = STAT_BAD_ADDR;
               state_in  = S_DONE;
            end else begin
               q_in     = acc_ff[CNT_W-1:0];
               acc_in   = acc_ff >> CNT_W;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring divide, one quotient bit a cycle
            add_a   = {acc_ff[ADDR_W-2:0], q_ff[CNT_W-1]};
            add_b   = ADDR_W'(size_ff);
            add_sub = 1'b1;
            if (add_sum[ADDR_W]) begin
               acc_in = add_sum[ADDR_W-1:0];
               q_in   = {q_ff[CNT_W-2:0], 1'b1};
            end else begin
               acc_in = add_a;
               q_in   = {q_ff[CNT_W-2:0], 1'b0};
            end
            if (cnt_ff == '0) begin
               state_in = S_CHECK;
            end else begin
               cnt_in = cnt_ff - STEP_W'(1);
            end
         end
         S_CHECK: begin
            if (acc_ff != '0 || q_ff >= count_eff) begin
               status_in = STAT_BAD_ADDR;
            end else if (fill_ff == CNT_W'(MAX_BLOCKS)) begin
               status_in = STAT_FULL;    // only reachable through a double free
            end else begin
               mem_we    = 1'b1;
               wr_ptr_in = ptr_next(wr_ptr_ff);
               fill_in   = fill_ff + CNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = (func_ff == FUNC_FREE) ? '0 : acc_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= BASE_RST;
         size_ff      <= SIZE_RST;
         count_ff     <= COUNT_RST;
         fresh_ff     <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fresh_ff     <= fresh_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_bus.valid) begin
            case (csr_bus.index)
               CSR_BASE:  base_ff  <= csr_bus.data;
               CSR_SIZE:  size_ff  <= csr_bus.data[SIZE_W-1:0];
               CSR_COUNT: count_ff <= csr_bus.data[COUNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ---------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      addr_ff       <= addr_in;
      acc_ff        <= acc_in;
      q_ff          <= q_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   // ------------------------------------------------------------- queue RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem[wr_ptr_ff] <= q_ff[IDX_W-1:0];
      end
      rd_q_ff <= queue_mem[rd_ptr_ff];
   end

   // ------------------------------------------------------------ assertions
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(MAX_BLOCKS))
      else $error("return queue fill above depth");

   a_fresh_bound: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= CNT_W'(MAX_BLOCKS))
      else $error("fresh counter above depth");

   a_write_not_full: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> fill_ff < CNT_W'(MAX_BLOCKS))
      else $error("queue write while full");

   a_err_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> rsp_addr_ff == '0)
      else $error("error word with nonzero address");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for fixed_block_pool_allocator: directed and random alloc/return words
// scored against an in-bench model of the pool. Needs fbpa_pkg, fbpa_if.sv and the RTL.
module tb_top;
   import fbpa_pkg::*;

   localparam int unsigned POOL_DEPTH  = 1024;
   localparam int unsigned CYCLE_LIMIT = 2_000_000;
   localparam int unsigned HOLD_CYCLES = 400;
   localparam int unsigned FLOOD_WORDS = 1100;
   localparam int unsigned MIXED_WORDS = 110;
   localparam int unsigned PHASES      = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic [ADDR_W-1:0]    ADDR_TOP  = '1;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] addr;
   } pool_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_address;
      status_type        status;
   } grant_type;

   logic clock;
   logic reset;

   fbpa_req_if req_bus();
   fbpa_rsp_if rsp_bus();
   fbpa_csr_if csr_bus();

   fixed_block_pool_allocator u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // ---------------------------------------------------------------------
   // Pool model: config copy, fresh counter and the FIFO of returned indexes
   // ---------------------------------------------------------------------
   logic [ADDR_W-1:0]  cfg_base;
   logic [SIZE_W-1:0]  cfg_size;
   logic [COUNT_W-1:0] cfg_count;
   int unsigned        fresh_cnt;
   int unsigned        ret_idx [POOL_DEPTH];
   int unsigned        ret_rd;
   int unsigned        ret_wr;
   int unsigned        ret_fill;

   // request words waiting to be offered, and grants owed by the block
   pool_req_type req_backlog [$];
   grant_type    grant_fifo [$];
   pool_req_type cur_req;
   bit          offering    = 1'b0;
   bit          quiet_mode  = 1'b0;   // no idle cycles on either side
   int unsigned req_gap     = 0;
   int unsigned rsp_stall   = 0;
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   // long back-pressure: the stimulus asks, the hold process counts it out
   int unsigned hold_asks  = 0;
   int unsigned hold_taken;
   int unsigned hold_left;
   logic        rsp_hold;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // count above the RAM depth behaves as the full depth
   function automatic logic [63:0] live_count();
      return (cfg_count > POOL_DEPTH) ? 64'(POOL_DEPTH) : 64'(cfg_count);
   endfunction

   // address of block idx from the current base and size, cut to 48 bits
   function automatic logic [ADDR_W-1:0] block_at(input int unsigned idx);
      logic [63:0] sum;
      sum = 64'(cfg_base) + 64'(idx) * 64'(cfg_size);
      return sum[ADDR_W-1:0];
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [ADDR_W-1:0] data);
      case (idx)
         CSR_BASE:  cfg_base  = data;
         CSR_SIZE:  cfg_size  = data[SIZE_W-1:0];
         CSR_COUNT: cfg_count = data[COUNT_W-1:0];
         default: ;
      endcase
   endfunction

   // grant for one accepted request word; advances the model state
   function automatic grant_type predict_grant(input pool_req_type r);
      grant_type   g;
      logic [63:0] lim;
      logic [63:0] off;
      g.block_address = '0;
      g.status        = STAT_OK;
      if (r.func == FUNC_ALLOC) begin
         if (64'(fresh_cnt) < live_count()) begin
            g.block_address = block_at(fresh_cnt);
            fresh_cnt++;
         end else if (ret_fill > 0) begin
            g.block_address = block_at(ret_idx[ret_rd]);
            ret_rd = (ret_rd + 1) % POOL_DEPTH;
            ret_fill--;
         end else begin
            g.status = STAT_EMPTY;
         end
      end else begin
         // limit is formed unwrapped, so a region past 2^48 still bounds correctly
         lim = 64'(cfg_base) + 64'(cfg_size) * live_count();
         if (cfg_size == 0 || r.addr < cfg_base || 64'(r.addr) >= lim) begin
            g.status = STAT_BAD_ADDR;
         end else begin
            off = 64'(r.addr) - 64'(cfg_base);
            if (off % 64'(cfg_size) != 0) begin
               g.status = STAT_BAD_ADDR;
            end else if (ret_fill >= POOL_DEPTH) begin
               g.status = STAT_FULL;
            end else begin
               ret_idx[ret_wr] = int'(off / 64'(cfg_size));
               ret_wr = (ret_wr + 1) % POOL_DEPTH;
               ret_fill++;
            end
         end
      end
      return g;
   endfunction

   // mostly back-to-back or short gaps, the odd long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (quiet_mode)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_W-1:0];
   endfunction

   // ---------------------------------------------------------------------
   // Return-address shapes for the random part
   // ---------------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] good_free_addr();
      int unsigned n;
      n = int'(live_count());
      return block_at((n > 0) ? $urandom_range(0, n - 1) : 0);
   endfunction

   function automatic logic [ADDR_W-1:0] misaligned_addr();
      logic [63:0] a;
      if (cfg_size < 2)
         return rand_addr();
      a = 64'(good_free_addr()) + 64'($urandom_range(1, cfg_size - 1));
      return a[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] outside_addr();
      logic [63:0] a;
      if (cfg_base == 0 || $urandom_range(0, 1) == 1)
         a = 64'(cfg_base) + 64'(cfg_size) * live_count()
             + 64'($urandom_range(0, 3)) * 64'(cfg_size);
      else
         a = 64'(cfg_base) - 64'($urandom_range(1, 256));
      return a[ADDR_W-1:0];
   endfunction

   // alloc words carry a random addr to show that the field is ignored
   task automatic push_alloc();
      req_backlog.insert(req_backlog.size(), '{FUNC_ALLOC, rand_addr()});
   endtask

   task automatic push_free(input logic [ADDR_W-1:0] a);
      req_backlog.insert(req_backlog.size(), '{FUNC_FREE, a});
   endtask

   task automatic push_mixed();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45)
         push_alloc();
      else if (r < 80)
         push_free(good_free_addr());
      else if (r < 87)
         push_free(misaligned_addr());
      else if (r < 93)
         push_free(outside_addr());
      else
         push_free(rand_addr());
   endtask

   // ---------------------------------------------------------------------
   // CSR writes: called on a clock edge; valid stays up across back-to-back
   // writes and is dropped once by set_pool after the last one
   // ---------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      apply_csr(idx, data);
   endtask

   // junk in the unused upper data bits must be masked off by the block
   task automatic set_pool(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                           input logic [COUNT_W-1:0] count);
      logic [ADDR_W-1:0] junk;
      junk = rand_addr();
      csr_write(CSR_BASE, base);
      csr_write(CSR_SIZE, {junk[ADDR_W-1:SIZE_W], size});
      csr_write(CSR_COUNT, {junk[ADDR_W-1:COUNT_W], count});
      csr_bus.valid <= 1'b0;
   endtask

   // every word offered, accepted and answered, then a settling pause
   task automatic wait_drained(input int unsigned settle);
      do @(posedge clock);
      while (req_backlog.size() != 0 || offering || grant_fifo.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Request driver: one word offered at a time, prediction taken on accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         cur_req       = '{FUNC_ALLOC, '0};
         offering      = 1'b0;
         req_gap       = 0;
         req_bus.valid <= 1'b0;
         req_bus.func  <= cur_req.func;
         req_bus.addr  <= cur_req.addr;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            grant_fifo.insert(grant_fifo.size(), predict_grant(cur_req));
            offering = 1'b0;
         end
         if (!offering) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (req_backlog.size() > 0) begin
               cur_req  = req_backlog[0];
               req_backlog.delete(0);
               offering = 1'b1;
               req_gap  = pick_gap();
            end
         end
         // single assignment per edge keeps valid high across back-to-back words
         req_bus.valid <= offering;
         req_bus.func  <= cur_req.func;
         req_bus.addr  <= cur_req.addr;
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: compare each word with the oldest owed grant
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      grant_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (grant_fifo.size() == 0) begin
               $display("%0t: unexpected response word: addr %h status %0d",
                        $time, rsp_bus.block_address, rsp_bus.status);
               fail_count++;
            end else begin
               want = grant_fifo[0];
               grant_fifo.delete(0);
               if (rsp_bus.block_address !== want.block_address) begin
                  $display("%0t: block_address mismatch: expected %h, actual %h",
                           $time, want.block_address, rsp_bus.block_address);
                  fail_count++;
               end
               if (rsp_bus.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                           $time, want.status, want.status.name(), rsp_bus.status);
                  fail_count++;
               end
            end
            rsp_stall = pick_gap();
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_bus.ready <= !rsp_hold && rsp_stall == 0;
      end
   end

   // long hold-off on the response side; the block fills and stalls req
   always @(posedge clock) begin
      if (reset) begin
         hold_taken <= 0;
         hold_left  <= 0;
         rsp_hold   <= 1'b0;
      end else if (hold_taken != hold_asks) begin
         hold_taken <= hold_asks;
         hold_left  <= HOLD_CYCLES;
         rsp_hold   <= 1'b1;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
      end else begin
         hold_left <= 0;
         rsp_hold  <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin : stimulus
      logic [ADDR_W-1:0]  base;
      logic [SIZE_W-1:0]  size;
      logic [COUNT_W-1:0] count;

      cfg_base  = BASE_RST;
      cfg_size  = SIZE_RST;
      cfg_count = COUNT_RST;
      fresh_cnt = 0;
      ret_rd    = 0;
      ret_wr    = 0;
      ret_fill  = 0;

      reset         <= 1'b1;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_BASE;
      csr_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset config (base 0, 256 B blocks, 1024 of them)
      push_alloc();                    // first fresh block, address 0
      push_free('0);                   // good return
      push_free(48'd1);                // off the block grid
      push_free(48'd256 * 48'd1024);   // one past the region
      push_free(ADDR_TOP);             // top of the address space
      push_alloc();                    // fresh again, queue left alone
      wait_drained(4);

      // near-top base with a 2^24 size: fresh address wraps at 48 bits;
      // count 3 now sits just above fresh_issued; spare index must be ignored
      base = ADDR_TOP - 48'hFF;
      csr_write(CSR_SPARE, rand_addr());
      set_pool(base, 25'd1 << 24, 11'd3);
      push_alloc();                    // last fresh block, wrapped
      push_alloc();                    // from the queue, old index under new config
      push_alloc();                    // pool empty
      push_free('0);                   // below base
      push_free(base);
      push_alloc();
      wait_drained(4);

      // zero size with a count above the RAM depth
      set_pool(48'h1000, '0, 11'd2047);
      push_alloc();                    // every fresh block lands on base
      push_free(48'h1000);             // any return is bad with zero size
      push_alloc();
      wait_drained(4);

      // zero count
      set_pool(48'h1000, 25'd1, '0);
      push_alloc();
      push_free(48'h1000);
      wait_drained(4);

      // largest size field, count shrunk below fresh_issued; double free
      set_pool('0, '1, 11'd1);
      push_alloc();
      push_free('0);
      push_free('0);
      push_alloc();
      push_alloc();
      push_alloc();
      wait_drained(4);

      // --- random phases
      for (int ph = 0; ph < PHASES; ph++) begin
         quiet_mode = (ph % 3 == 1);
         if (ph == 3) begin
            // flood: double frees over a tiny region overrun the queue and wrap the pointers
            set_pool(rand_addr(), 25'($urandom_range(1, 64)), 11'($urandom_range(2, 8)));
            for (int i = 0; i < FLOOD_WORDS; i++) begin
               if ($urandom_range(0, 99) == 0)
                  push_alloc();
               else
                  push_free(good_free_addr());
            end
            hold_asks++;
         end else begin
            case ($urandom_range(0, 5))
               0:       base = '0;
               1:       base = ADDR_TOP - 48'($urandom_range(0, 1 << 20));
               default: base = rand_addr();
            endcase
            case ($urandom_range(0, 9))
               0:       size = 25'd1;
               1:       size = 25'd1 << 24;
               2:       size = '1;
               3:       size = '0;
               4, 5:    size = 25'd1 << $urandom_range(0, 12);
               default: size = 25'($urandom_range(1, 4096));
            endcase
            case ($urandom_range(0, 9))
               0:       count = 11'd1;
               1:       count = 11'd1024;
               2:       count = 11'd2047;
               3:       count = '0;
               default: count = 11'($urandom_range(1, 1024));
            endcase
            set_pool(base, size, count);
            for (int i = 0; i < MIXED_WORDS; i++)
               push_mixed();
            if (ph == 6)
               hold_asks++;
         end
         wait_drained(4);
      end

      quiet_mode = 1'b0;
      wait_drained(40);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
